@@ rtl/fdl_pkg.sv @@
// Shared types and constants of the fractional delay line.
`timescale 1ns / 1ps

package fdl_pkg;

    // Configuration of the store
    localparam int CHANNELS   = 2;
    localparam int DEPTH_LOG2 = 16;
    localparam int DEPTH      = 1 << DEPTH_LOG2;
    localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int MEM_DEPTH  = CHANNELS << DEPTH_LOG2;
    localparam int ADDR_W     = $clog2(MEM_DEPTH);

    // Sample and fixed-point widths
    localparam int SAMPLE_W = 24;
    localparam int FRAC_W   = 16;
    localparam int DELAY_W  = 32;
    localparam int POS_W    = DEPTH_LOG2 + FRAC_W;
    localparam int DCMP_W   = (POS_W > DELAY_W) ? POS_W : DELAY_W;

    // Delay clamp bounds in Q16.16
    localparam logic [DCMP_W-1:0] DMIN = DCMP_W'({2'd2, 16'h0000});
    localparam logic [DCMP_W-1:0] DMAX = DCMP_W'({DEPTH_LOG2'(DEPTH - 3), 16'h0000});

    // Interpolator widths
    localparam int COEF_W = 28;
    localparam int ACC_W  = 48;
    localparam int RQ_W   = ACC_W - FRAC_W - 1;

    // Command queue
    localparam int CQ_DEPTH = 4;
    localparam int CQ_AW    = 2;

    // Function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    // One command from the front end to the back end
    typedef struct packed {
        logic                  is_read;
        logic                  bad;
        logic [CH_W-1:0]       chan;
        logic [DEPTH_LOG2-1:0] idx;     // write slot or read base
        logic [FRAC_W-1:0]     frac;
        logic [SAMPLE_W-1:0]   sample;
    } t_cmd;

    // Queue status seen by the front end
    typedef struct packed {
        logic full;
        logic empty;
    } t_cq_stat;

endpackage

@@ rtl/fractional_delay_line_cubic.sv @@
// Top level of the multichannel fractional delay line with cubic interpolation.
// Usage:
//   Input side is a queue: drive a word and raise i_push; it is taken on a clock
//   edge where o_full is low. i_func selects a sample write or an interpolated read.
//   Writes store i_sample_in for i_channel at the shared write head; i_end_of_frame
//   advances the head afterwards. Writes to a channel at or above CHANNELS store
//   nothing but still honor end of frame.
//   Result side is a single register: while o_empty is low the result sits on
//   o_sample_out / o_bad_channel and is removed on an edge with i_pop high.
//   Only reads produce results, one each, in order.
// Timing:
//   The back end retires a write in the cycle it dequeues it. A read passes
//   through dequeue, fetch of the four taps via the single read port of the
//   sample store, forming of the coefficients, three Horner steps (multiply,
//   then add), and round and saturate. No new command is taken until a read is
//   done, and the finish step waits while a result is still held. A four-entry
//   command queue lets the input side keep accepting while the back end works or
//   while a finished result waits for i_pop.
// Reset:
//   The sample store is swept to zero one entry per cycle, all CHANNELS *
//   2^DEPTH_LOG2 entries (131072 here); o_full stays high for the whole pass.
//   A stalled receiver holds the result register and the back end in its finish
//   step; the queue fills and o_full then rises.
`timescale 1ns / 1ps

module fractional_delay_line_cubic (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    output logic                               o_full,
    input  logic                               i_func,
    input  logic [3:0]                         i_channel,
    input  logic signed [fdl_pkg::SAMPLE_W-1:0] i_sample_in,
    input  logic                               i_end_of_frame,
    input  logic [fdl_pkg::DELAY_W-1:0]        i_delay,
    input  logic                               i_pop,
    output logic                               o_empty,
    output logic signed [fdl_pkg::SAMPLE_W-1:0] o_sample_out,
    output logic                               o_bad_channel
);

    fdl_pkg::t_cmd     front_cmd;
    fdl_pkg::t_cmd     queue_cmd;
    fdl_pkg::t_cq_stat cq_stat;
    logic              cq_push;
    logic              cq_pop;
    logic              back_busy;

    fdl_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .i_func         (i_func),
        .i_channel      (i_channel),
        .i_sample_in    (i_sample_in),
        .i_end_of_frame (i_end_of_frame),
        .i_delay        (i_delay),
        .i_busy         (back_busy),
        .i_cq_stat      (cq_stat),
        .o_full         (o_full),
        .o_cq_push      (cq_push),
        .o_cmd          (front_cmd)
    );

    fdl_cmd_fifo u_cq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cq_push),
        .i_cmd   (front_cmd),
        .i_pop   (cq_pop),
        .o_stat  (cq_stat),
        .o_cmd   (queue_cmd)
    );

    fdl_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cq_stat     (cq_stat),
        .i_cmd         (queue_cmd),
        .o_cq_pop      (cq_pop),
        .o_busy        (back_busy),
        .i_pop         (i_pop),
        .o_empty       (o_empty),
        .o_sample_out  (o_sample_out),
        .o_bad_channel (o_bad_channel)
    );

endmodule

@@ rtl/fdl_front.sv @@
// Front end: accepts words, tracks the write head, computes tap base and fraction.
`timescale 1ns / 1ps

module fdl_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    input  logic                             i_func,
    input  logic [3:0]                       i_channel,
    input  logic signed [fdl_pkg::SAMPLE_W-1:0] i_sample_in,
    input  logic                             i_end_of_frame,
    input  logic [fdl_pkg::DELAY_W-1:0]      i_delay,
    input  logic                             i_busy,
    input  fdl_pkg::t_cq_stat                i_cq_stat,
    output logic                             o_full,
    output logic                             o_cq_push,
    output fdl_pkg::t_cmd                    o_cmd
);

    logic [fdl_pkg::DEPTH_LOG2-1:0] r_head;
    logic [fdl_pkg::DEPTH_LOG2-1:0] n_head;
    logic                           accept;
    logic                           ch_ok;
    logic [fdl_pkg::DCMP_W-1:0]     d_ext;
    logic [fdl_pkg::DCMP_W-1:0]     d_clamp;
    logic [fdl_pkg::POS_W-1:0]      pos;

    assign o_full = i_busy || i_cq_stat.full;
    assign accept = i_push && !o_full;
    assign ch_ok  = i_channel < 4'(fdl_pkg::CHANNELS);

    always_comb begin
        d_ext = fdl_pkg::DCMP_W'(i_delay);
        if (d_ext < fdl_pkg::DMIN) begin
            d_clamp = fdl_pkg::DMIN;
        end else if (d_ext > fdl_pkg::DMAX) begin
            d_clamp = fdl_pkg::DMAX;
        end else begin
            d_clamp = d_ext;
        end
        // ring position, wraps modulo the depth
        pos = {r_head, 16'h0000} - d_clamp[fdl_pkg::POS_W-1:0];
    end

    always_comb begin
        o_cmd.is_read = (i_func == fdl_pkg::FUNC_READ);
        o_cmd.bad     = !ch_ok;
        o_cmd.chan    = i_channel[fdl_pkg::CH_W-1:0];
        o_cmd.idx     = (i_func == fdl_pkg::FUNC_READ) ?
                        pos[fdl_pkg::POS_W-1:fdl_pkg::FRAC_W] : r_head;
        o_cmd.frac    = pos[fdl_pkg::FRAC_W-1:0];
        o_cmd.sample  = i_sample_in;
        // bad-channel writes store nothing, so they never reach the back end
        o_cq_push     = accept && ((i_func == fdl_pkg::FUNC_READ) || ch_ok);
    end

    always_comb begin
        n_head = r_head;
        if (accept && (i_func == fdl_pkg::FUNC_WRITE) && i_end_of_frame) begin
            n_head = r_head + fdl_pkg::DEPTH_LOG2'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
        end else begin
            r_head <= n_head;
        end
    end

endmodule

@@ rtl/fdl_cmd_fifo.sv @@
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps

module fdl_cmd_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  fdl_pkg::t_cmd     i_cmd,
    input  logic              i_pop,
    output fdl_pkg::t_cq_stat o_stat,
    output fdl_pkg::t_cmd     o_cmd
);

    fdl_pkg::t_cmd              r_q [fdl_pkg::CQ_DEPTH];
    logic [fdl_pkg::CQ_AW-1:0]  r_wp;
    logic [fdl_pkg::CQ_AW-1:0]  r_rp;
    logic [fdl_pkg::CQ_AW:0]    r_cnt;
    logic                       do_push;
    logic                       do_pop;

    assign o_stat.full  = (r_cnt == (fdl_pkg::CQ_AW + 1)'(fdl_pkg::CQ_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_cmd        = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + fdl_pkg::CQ_AW'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + fdl_pkg::CQ_AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + (fdl_pkg::CQ_AW + 1)'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - (fdl_pkg::CQ_AW + 1)'(1);
            end
        end
    end

endmodule

@@ rtl/fdl_back.sv @@
// Back end: sample store, tap fetch, Horner interpolator and result register.
`timescale 1ns / 1ps

module fdl_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  fdl_pkg::t_cq_stat                  i_cq_stat,
    input  fdl_pkg::t_cmd                      i_cmd,
    output logic                               o_cq_pop,
    output logic                               o_busy,
    input  logic                               i_pop,
    output logic                               o_empty,
    output logic signed [fdl_pkg::SAMPLE_W-1:0] o_sample_out,
    output logic                               o_bad_channel
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_TAP,
        S_COEF,
        S_MUL,
        S_ADD,
        S_DONE
    } t_state;

    t_state r_state;

    // sample store
    logic [fdl_pkg::SAMPLE_W-1:0] r_mem [fdl_pkg::MEM_DEPTH];
    logic [fdl_pkg::SAMPLE_W-1:0] r_rd;
    logic                         mem_we;
    logic [fdl_pkg::ADDR_W-1:0]   mem_waddr;
    logic [fdl_pkg::SAMPLE_W-1:0] mem_wdata;
    logic [fdl_pkg::ADDR_W-1:0]   mem_raddr;

    logic [fdl_pkg::ADDR_W-1:0]     r_clr_addr;
    logic [fdl_pkg::CH_W-1:0]       r_chan;
    logic [fdl_pkg::DEPTH_LOG2-1:0] r_base;
    logic [fdl_pkg::FRAC_W-1:0]     r_frac;
    logic                           r_bad;
    logic [2:0]                     r_tap;
    logic [1:0]                     r_step;
    logic signed [fdl_pkg::SAMPLE_W-1:0] r_y [4];
    logic signed [fdl_pkg::COEF_W-1:0]   r_b2;
    logic signed [fdl_pkg::COEF_W-1:0]   r_c2;
    logic signed [fdl_pkg::ACC_W-1:0]    r_acc;
    logic signed [fdl_pkg::ACC_W-1:0]    r_phi;
    logic [fdl_pkg::FRAC_W-1:0]          r_plo;
    logic                                r_out_valid;
    logic signed [fdl_pkg::SAMPLE_W-1:0] r_out_sample;
    logic                                r_out_bad;

    logic signed [fdl_pkg::COEF_W-1:0]   ym1, y0, y1, y2, a2, b2, c2, addend;
    logic signed [fdl_pkg::ACC_W:0]      hi_prod;
    logic [2*fdl_pkg::FRAC_W-1:0]        lo_prod;
    logic signed [fdl_pkg::ACC_W-1:0]    rnd;
    logic signed [fdl_pkg::RQ_W-1:0]     q;
    logic signed [fdl_pkg::SAMPLE_W-1:0] res;
    logic                                out_free;
    logic [fdl_pkg::DEPTH_LOG2-1:0]      tap_idx;

    // ---------------- store ----------------
    assign tap_idx   = r_base + fdl_pkg::DEPTH_LOG2'(r_tap[1:0])
                       - fdl_pkg::DEPTH_LOG2'(1);
    assign mem_raddr = fdl_pkg::ADDR_W'({r_chan, tap_idx});
    assign o_busy    = (r_state == S_CLEAR);
    assign o_cq_pop  = (r_state == S_IDLE) && !i_cq_stat.empty;

    always_comb begin
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else begin
            mem_we    = o_cq_pop && !i_cmd.is_read;
            mem_waddr = fdl_pkg::ADDR_W'({i_cmd.chan, i_cmd.idx});
            mem_wdata = i_cmd.sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= r_mem[mem_raddr];
    end

    // ---------------- arithmetic ----------------
    always_comb begin
        ym1 = fdl_pkg::COEF_W'(r_y[0]);
        y0  = fdl_pkg::COEF_W'(r_y[1]);
        y1  = fdl_pkg::COEF_W'(r_y[2]);
        y2  = fdl_pkg::COEF_W'(r_y[3]);
        a2  = -ym1 + 28'sd3 * y0 - 28'sd3 * y1 + y2;
        b2  = 28'sd2 * ym1 - 28'sd5 * y0 + 28'sd4 * y1 - y2;
        c2  = y1 - ym1;
        case (r_step)
            2'd0:    addend = r_b2;
            2'd1:    addend = r_c2;
            default: addend = 28'sd2 * y0;
        endcase
        // acc*T/2^16 split as hi*T + floor(lo*T/2^16), exact
        hi_prod = $signed(r_acc[fdl_pkg::ACC_W-1:fdl_pkg::FRAC_W])
                  * $signed({1'b0, r_frac});
        lo_prod = r_acc[fdl_pkg::FRAC_W-1:0] * r_frac;
        rnd     = r_acc + fdl_pkg::ACC_W'(65536);
        q       = rnd[fdl_pkg::ACC_W-1:fdl_pkg::FRAC_W+1];
        if (q > fdl_pkg::RQ_W'(24'sh7FFFFF)) begin
            res = 24'sh7FFFFF;
        end else if (q < -fdl_pkg::RQ_W'(25'sh0800000)) begin
            res = 24'sh800000;
        end else begin
            res = q[fdl_pkg::SAMPLE_W-1:0];
        end
    end

    assign out_free = !r_out_valid || i_pop;

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_tap       <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // in S_DONE the finish step below owns the valid flag
            if (r_out_valid && i_pop && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + fdl_pkg::ADDR_W'(1);
                    if (r_clr_addr == fdl_pkg::ADDR_W'(fdl_pkg::MEM_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (o_cq_pop && i_cmd.is_read) begin
                        r_chan <= i_cmd.chan;
                        r_base <= i_cmd.idx;
                        r_frac <= i_cmd.frac;
                        r_bad  <= i_cmd.bad;
                        r_tap  <= '0;
                        r_step <= '0;
                        r_state <= i_cmd.bad ? S_DONE : S_TAP;
                    end
                end
                S_TAP: begin
                    // address for tap r_tap goes out, data of the previous tap returns
                    if (r_tap != 3'd0) begin
                        r_y[r_tap[1:0] - 2'd1] <= r_rd;
                    end
                    r_tap <= r_tap + 3'd1;
                    if (r_tap == 3'd4) begin
                        r_state <= S_COEF;
                    end
                end
                S_COEF: begin
                    r_b2    <= b2;
                    r_c2    <= c2;
                    r_acc   <= fdl_pkg::ACC_W'(a2) <<< fdl_pkg::FRAC_W;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_phi   <= hi_prod[fdl_pkg::ACC_W-1:0];
                    r_plo   <= lo_prod[2*fdl_pkg::FRAC_W-1:fdl_pkg::FRAC_W];
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_acc  <= r_phi + fdl_pkg::ACC_W'(r_plo)
                              + (fdl_pkg::ACC_W'(addend) <<< fdl_pkg::FRAC_W);
                    r_step <= r_step + 2'd1;
                    r_state <= (r_step == 2'd2) ? S_DONE : S_MUL;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_bad    <= r_bad;
                        r_out_sample <= r_bad ? '0 : res;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_empty       = !r_out_valid;
    assign o_sample_out  = r_out_sample;
    assign o_bad_channel = r_out_bad;

    // ---------------- checks ----------------
    a_no_pop_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_cq_pop)
        else $error("command taken during clearing pass");

    a_coef_after_taps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COEF) |-> ($past(r_state) == S_TAP))
        else $error("coefficients formed before all taps were fetched");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result register loaded outside the finish step");

    a_bad_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_bad) |-> (r_out_sample == '0))
        else $error("bad-channel result carries a nonzero sample");

endmodule
